@@ sv/c8x_pkg.sv @@
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types, codes and helpers for the CHIP-8 instruction executor.
// ----------------------------------------------------------------------------
`default_nettype none

package c8x_pkg;

  localparam int ADDR_W    = 12;
  localparam int MEM_BYTES = 4096;
  localparam int FB_BYTES  = 256;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 24;

  localparam logic [ADDR_W-1:0] START_RESET = 12'h200;
  localparam logic [ADDR_W-1:0] PC_LAST     = 12'hfff;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_EXEC  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_FRAME = 2'd3;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_HALT   = 2'd1;
  localparam logic [1:0] STS_STACK  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_MWR, ST_MRD, ST_MRD2, ST_FRD, ST_FRD2, ST_HALT,
    ST_F0, ST_F1, ST_F2, ST_RVX, ST_RVY, ST_EXEC, ST_VF,
    ST_DM, ST_DF0, ST_DW0, ST_DF1, ST_DW1, ST_DNX, ST_DVF,
    ST_B0, ST_B1, ST_B2, ST_ST, ST_LD0, ST_LD1, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    K_PLAIN, K_FLAG, K_DRAW, K_BCD, K_STORE, K_LOAD
  } kind_t;

  typedef struct packed {
    logic   take;
    logic   out_load;
    state_t step;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       halted;
    logic       pc_end;
    kind_t      kind;
    logic       row_end;
    logic       right_ok;
    logic       last;
    logic       out_free;
  } dp_stat_t;

  // hundreds, tens, ones of an 8-bit value
  function automatic logic [11:0] bcd3(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [15:0] p;
    logic [3:0]  t;
    logic [7:0]  o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - ({6'd0, h} * 8'd100);
    p = {8'h00, r} * 16'd205;
    t = p[14:11];
    o = r - {t, 3'b000} - {3'b000, t, 1'b0};
    return {2'b00, h, t, o[3:0]};
  endfunction

endpackage

`default_nettype wire

@@ sv/c8x_ctrl.sv @@
// ----------------------------------------------------------------------------
// c8x_ctrl
// Sequencer: memory and frame commands, or fetch, decode and execute steps.
// ----------------------------------------------------------------------------
`default_nettype none

module c8x_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire c8x_pkg::dp_stat_t stat,
  output c8x_pkg::ctl_cmd_t      cmd
);
  import c8x_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.take     = 1'b0;
    cmd.out_load = 1'b0;
    cmd.step     = state_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        case (stat.cmd)
          CMD_WRITE: state_nxt = ST_MWR;
          CMD_READ:  state_nxt = ST_MRD;
          CMD_FRAME: state_nxt = ST_FRD;
          default: begin
            if (stat.halted)      state_nxt = ST_DONE;
            else if (stat.pc_end) state_nxt = ST_HALT;
            else                  state_nxt = ST_F0;
          end
        endcase
      end
      ST_MWR:  state_nxt = ST_DONE;
      ST_MRD:  state_nxt = ST_MRD2;
      ST_MRD2: state_nxt = ST_DONE;
      ST_FRD:  state_nxt = ST_FRD2;
      ST_FRD2: state_nxt = ST_DONE;
      ST_HALT: state_nxt = ST_DONE;
      ST_F0:   state_nxt = ST_F1;
      ST_F1:   state_nxt = ST_F2;
      ST_F2:   state_nxt = ST_RVX;
      ST_RVX:  state_nxt = ST_RVY;
      ST_RVY:  state_nxt = ST_EXEC;
      ST_EXEC: begin
        case (stat.kind)
          K_FLAG:  state_nxt = ST_VF;
          K_DRAW:  state_nxt = ST_DM;
          K_BCD:   state_nxt = ST_B0;
          K_STORE: state_nxt = ST_ST;
          K_LOAD:  state_nxt = ST_LD0;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_VF:   state_nxt = ST_DONE;
      ST_DM:   state_nxt = stat.row_end ? ST_DVF : ST_DF0;
      ST_DF0:  state_nxt = ST_DW0;
      ST_DW0:  state_nxt = stat.right_ok ? ST_DF1 : ST_DNX;
      ST_DF1:  state_nxt = ST_DW1;
      ST_DW1:  state_nxt = ST_DNX;
      ST_DNX:  state_nxt = ST_DM;
      ST_DVF:  state_nxt = ST_DONE;
      ST_B0:   state_nxt = ST_B1;
      ST_B1:   state_nxt = ST_B2;
      ST_B2:   state_nxt = ST_DONE;
      ST_ST:   state_nxt = stat.last ? ST_DONE : ST_ST;
      ST_LD0:  state_nxt = ST_LD1;
      ST_LD1:  state_nxt = stat.last ? ST_DONE : ST_LD0;
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/c8x_datapath.sv @@
// ----------------------------------------------------------------------------
// c8x_datapath
// Memory, frame buffer, registers, stack and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module c8x_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire c8x_pkg::ctl_cmd_t           cmd,
  input  wire logic [c8x_pkg::IN_W-1:0]    in_tdata,
  input  wire logic                        cfg_wr_en,
  input  wire logic [c8x_pkg::ADDR_W-1:0]  cfg_wr_data,
  input  wire logic                        out_tready,
  output logic                             out_tvalid,
  output logic [c8x_pkg::OUT_W-1:0]        out_tdata,
  output c8x_pkg::dp_stat_t                stat
);
  import c8x_pkg::*;

  localparam int SPW  = $clog2(STACK_DEPTH + 1);
  localparam int IDXW = $clog2(STACK_DEPTH);

  logic [1:0]        cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        wd_r, rnd_r;
  logic [15:0]       op_r;
  logic [7:0]        vx_r, vy_r, spr_r;
  logic [ADDR_W-1:0] pc_r, i_r;
  logic [SPW-1:0]    sp_r;
  logic              halted_r, fc_r, flag_r, hit_r;
  logic [1:0]        status_r;
  logic [7:0]        rd_r;
  logic [3:0]        cnt_r;
  logic [7:0]        v_r [16];
  logic [ADDR_W-1:0] stk [STACK_DEPTH];
  logic [7:0]        mem [MEM_BYTES];
  logic [7:0]        mem_q;
  logic [7:0]        fb [FB_BYTES];
  logic [7:0]        fb_q;
  logic [FB_BYTES-1:0] fv_r;
  logic              fv_q;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [3:0]        x, y, n;
  logic [7:0]        nn;
  logic [ADDR_W-1:0] nnn, i_k, mem_a;
  logic              mem_we;
  logic [7:0]        mem_wd;
  logic [7:0]        f_a, f_wd, fq, idx_l, idx_r;
  logic              f_we, fb_clear;
  logic [5:0]        row;
  logic [2:0]        colb;
  logic [15:0]       sh16;
  logic [3:0]        v_ra, v_wa;
  logic              v_we;
  logic [7:0]        v_rd, v_wd;
  logic [7:0]        alu_v;
  logic              alu_f;
  logic [8:0]        sum9;
  logic [11:0]       bcd;
  logic [SPW-1:0]    sp_m1;
  logic [1:0]        sts;
  kind_t             kind;

  assign x     = op_r[11:8];
  assign y     = op_r[7:4];
  assign n     = op_r[3:0];
  assign nn    = op_r[7:0];
  assign nnn   = op_r[11:0];
  assign i_k   = i_r + {8'h00, cnt_r};
  assign row   = {1'b0, vy_r[4:0]} + {2'b00, cnt_r};
  assign colb  = vx_r[5:3];
  assign sh16  = {spr_r, 8'h00} >> vx_r[2:0];
  assign idx_l = {row[4:0], colb};
  assign idx_r = {row[4:0], colb + 3'd1};
  assign fq    = fv_q ? fb_q : 8'h00;
  assign sum9  = {1'b0, vx_r} + {1'b0, vy_r};
  assign bcd   = bcd3(vx_r);
  assign sp_m1 = sp_r - SPW'(1);
  assign sts   = halted_r ? STS_HALT : status_r;
  assign v_rd  = v_r[v_ra];
  assign fb_clear = (cmd.step == ST_EXEC) && (op_r == 16'h00e0);

  always_comb begin
    kind = K_PLAIN;
    case (op_r[15:12])
      4'h8: begin
        if (n == 4'h4 || n == 4'h5 || n == 4'h6 || n == 4'h7 || n == 4'he) kind = K_FLAG;
      end
      4'hd: kind = K_DRAW;
      4'hf: begin
        if (nn == 8'h33)      kind = K_BCD;
        else if (nn == 8'h55) kind = K_STORE;
        else if (nn == 8'h65) kind = K_LOAD;
      end
      default: kind = K_PLAIN;
    endcase
  end

  always_comb begin
    alu_v = vx_r;
    alu_f = 1'b0;
    case (n)
      4'h0: alu_v = vy_r;
      4'h1: alu_v = vx_r | vy_r;
      4'h2: alu_v = vx_r & vy_r;
      4'h3: alu_v = vx_r ^ vy_r;
      4'h4: begin alu_v = sum9[7:0];    alu_f = sum9[8];         end
      4'h5: begin alu_v = vx_r - vy_r;  alu_f = (vx_r >= vy_r);  end
      4'h6: begin alu_v = {1'b0, vy_r[7:1]}; alu_f = vy_r[0];    end
      4'h7: begin alu_v = vy_r - vx_r;  alu_f = (vy_r >= vx_r);  end
      4'he: begin alu_v = {vy_r[6:0], 1'b0}; alu_f = vy_r[7];    end
      default: alu_v = vx_r;
    endcase
  end

  always_comb begin
    mem_a  = pc_r;
    mem_we = 1'b0;
    mem_wd = wd_r;
    case (cmd.step)
      ST_MWR: begin mem_a = addr_r; mem_we = 1'b1; end
      ST_MRD: mem_a = addr_r;
      ST_F1:  mem_a = pc_r + 12'd1;
      ST_DM:  mem_a = i_k;
      ST_B0:  begin mem_a = i_r;          mem_we = 1'b1; mem_wd = {4'h0, bcd[11:8]}; end
      ST_B1:  begin mem_a = i_r + 12'd1;  mem_we = 1'b1; mem_wd = {4'h0, bcd[7:4]};  end
      ST_B2:  begin mem_a = i_r + 12'd2;  mem_we = 1'b1; mem_wd = {4'h0, bcd[3:0]};  end
      ST_ST:  begin mem_a = i_k; mem_we = 1'b1; mem_wd = v_rd; end
      ST_LD0: mem_a = i_k;
      default: mem_a = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_a] <= mem_wd;
    mem_q <= mem[mem_a];
  end

  always_comb begin
    f_a  = idx_l;
    f_we = 1'b0;
    f_wd = fq ^ sh16[15:8];
    case (cmd.step)
      ST_FRD: f_a = addr_r[7:0];
      ST_DW0: f_we = 1'b1;
      ST_DF1: f_a = idx_r;
      ST_DW1: begin f_a = idx_r; f_we = 1'b1; f_wd = fq ^ sh16[7:0]; end
      default: f_a = idx_l;
    endcase
  end

  always_ff @(posedge clk) begin
    if (f_we) fb[f_a] <= f_wd;
    fb_q <= fb[f_a];
    fv_q <= fv_r[f_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (fb_clear) begin
      fv_r <= '0;
    end else if (f_we) begin
      fv_r[f_a] <= 1'b1;
    end
  end

  always_comb begin
    v_ra = x;
    case (cmd.step)
      ST_RVX: v_ra = (op_r[15:12] == 4'hb) ? 4'h0 : x;
      ST_RVY: v_ra = y;
      ST_ST:  v_ra = cnt_r;
      default: v_ra = x;
    endcase
  end

  always_comb begin
    v_we = 1'b0;
    v_wa = x;
    v_wd = alu_v;
    case (cmd.step)
      ST_EXEC: begin
        case (op_r[15:12])
          4'h6: begin v_we = 1'b1; v_wd = nn;          end
          4'h7: begin v_we = 1'b1; v_wd = vx_r + nn;   end
          4'h8: begin
            v_we = (n <= 4'h7) || (n == 4'he);
          end
          4'hc: begin v_we = 1'b1; v_wd = rnd_r & nn;  end
          default: v_we = 1'b0;
        endcase
      end
      ST_VF:  begin v_we = 1'b1; v_wa = 4'hf; v_wd = {7'd0, flag_r}; end
      ST_DVF: begin v_we = 1'b1; v_wa = 4'hf; v_wd = {7'd0, hit_r};  end
      ST_LD1: begin v_we = 1'b1; v_wa = cnt_r; v_wd = mem_q; end
      default: v_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 16; k++) v_r[k] <= 8'h00;
    end else if (v_we) begin
      v_r[v_wa] <= v_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == ST_EXEC && op_r[15:12] == 4'h2 && sp_r < SPW'(STACK_DEPTH)) begin
      stk[sp_r[IDXW-1:0]] <= pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cmd_r  <= in_tdata[1:0];
      addr_r <= in_tdata[13:2];
      wd_r   <= in_tdata[21:14];
      rnd_r  <= in_tdata[29:22];
    end
    case (cmd.step)
      ST_F1:  op_r[15:8] <= mem_q;
      ST_F2:  op_r[7:0]  <= mem_q;
      ST_RVX: vx_r <= v_rd;
      ST_RVY: vy_r <= v_rd;
      ST_EXEC: flag_r <= alu_f;
      ST_DF0: spr_r <= mem_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= START_RESET;
      i_r      <= '0;
      sp_r     <= '0;
      halted_r <= 1'b0;
      status_r <= STS_OK;
      rd_r     <= 8'h00;
      fc_r     <= 1'b0;
      cnt_r    <= 4'h0;
      hit_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      pc_r     <= cfg_wr_data;
      halted_r <= 1'b0;
    end else begin
      case (cmd.step)
        ST_DISP: begin
          status_r <= STS_OK;
          rd_r     <= 8'h00;
          fc_r     <= 1'b0;
        end
        ST_MRD2: rd_r <= mem_q;
        ST_FRD2: rd_r <= fq;
        ST_HALT: halted_r <= 1'b1;
        ST_F2:   pc_r <= pc_r + 12'd2;
        ST_EXEC: begin
          cnt_r <= 4'h0;
          hit_r <= 1'b0;
          case (op_r[15:12])
            4'h0: begin
              if (op_r == 16'h00e0) begin
                fc_r <= 1'b1;
              end else if (op_r == 16'h00ee) begin
                if (sp_r == '0) begin
                  status_r <= STS_STACK;
                end else begin
                  sp_r <= sp_m1;
                  pc_r <= stk[sp_m1[IDXW-1:0]];
                end
              end
            end
            4'h1: pc_r <= nnn;
            4'h2: begin
              if (sp_r >= SPW'(STACK_DEPTH)) begin
                status_r <= STS_STACK;
              end else begin
                sp_r <= sp_r + SPW'(1);
                pc_r <= nnn;
              end
            end
            4'h3: if (vx_r == nn) pc_r <= pc_r + 12'd2;
            4'h4: if (vx_r != nn) pc_r <= pc_r + 12'd2;
            4'h5: if (n == 4'h0 && vx_r == vy_r) pc_r <= pc_r + 12'd2;
            4'h9: if (n == 4'h0 && vx_r != vy_r) pc_r <= pc_r + 12'd2;
            4'ha: i_r <= nnn;
            4'hb: pc_r <= {4'h0, vx_r} + nnn;
            4'hd: fc_r <= 1'b1;
            default: ;
          endcase
        end
        ST_DW0: hit_r <= hit_r | (|(fq & sh16[15:8]));
        ST_DW1: hit_r <= hit_r | (|(fq & sh16[7:0]));
        ST_DNX: cnt_r <= cnt_r + 4'h1;
        ST_ST:  cnt_r <= cnt_r + 4'h1;
        ST_LD1: cnt_r <= cnt_r + 4'h1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= {1'b0, fc_r, rd_r, sts, pc_r};
  end

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;
  assign stat.cmd       = cmd_r;
  assign stat.halted    = halted_r;
  assign stat.pc_end    = (pc_r == PC_LAST);
  assign stat.kind      = kind;
  assign stat.row_end   = (cnt_r == n) || row[5];
  assign stat.right_ok  = (colb != 3'd7);
  assign stat.last      = (cnt_r == x);
  assign stat.out_free  = !out_valid_r || out_tready;

endmodule

`default_nettype wire

@@ sv/chip8_instruction_executor_top.sv @@
// ----------------------------------------------------------------------------
// chip8_instruction_executor_top
// CHIP-8 core: memory and frame commands, fetch and execute of one opcode.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Payload
// in_       in   in_tvalid/tready     command, address, write_data, random_byte
// out_      out  out_tvalid/tready    program_counter, status, read_data,
//                                     frame_changed
// cfg_      in   cfg_wr_en            start_address
//
// Steps: memory write via dispatch and write; reads via dispatch, address and data; opcodes
// via fetch, register reads, execute, then VF, per-row DXYN, per-register FX55/FX65 steps.
// Memory and frame buffer use one port each with registered read data.
// Reset: PC to 0x200, frame buffer cleared at once by per-byte valid bits.
// A result held in the output register blocks only the next result load.
// ----------------------------------------------------------------------------
`default_nettype none

module chip8_instruction_executor_top #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // command, address, write_data, random_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // program_counter, status, read_data, frame_changed
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_wr_data  // start_address
);
  import c8x_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  c8x_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  c8x_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .stat        (stat)
  );

endmodule

`default_nettype wire

@@ sv/c8x_checker.sv @@
// ----------------------------------------------------------------------------
// c8x_checker
// Port-level checks over time, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module c8x_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);
  import c8x_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while busy");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_fc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[22] |-> out_tdata[13:12] == STS_OK)
    else $error("frame change with bad status");

endmodule

bind chip8_instruction_executor_top c8x_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

@@ bench/chip8_instruction_executor_top_test.sv @@
// ----------------------------------------------------------------------------
// chip8_instruction_executor_top_test
// Self-checking bench for the CHIP-8 executor. Memory bytes are written on
// demand before anything reads them, then directed opcodes and random
// programs are run under several start addresses.
// Each result is compared with a predictor that models the core.
// ----------------------------------------------------------------------------
`default_nettype none

module chip8_instruction_executor_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import c8x_pkg::*;

  localparam logic [3:0] OP_SYS = 4'h0, OP_JP = 4'h1, OP_CALL = 4'h2, OP_SEQ = 4'h3;
  localparam logic [3:0] OP_SNE = 4'h4, OP_SEQR = 4'h5, OP_LDV = 4'h6, OP_ADDV = 4'h7;
  localparam logic [3:0] OP_ALU = 4'h8, OP_SNER = 4'h9, OP_LDI = 4'ha, OP_JPV = 4'hb;
  localparam logic [3:0] OP_RND = 4'hc, OP_DRW = 4'hd, OP_MISC = 4'hf;
  localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_RSUB = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'he;
  localparam logic [7:0] MISC_BCD = 8'h33, MISC_STORE = 8'h55, MISC_LOAD = 8'h65;
  localparam logic [15:0] OP_CLS = 16'h00e0, OP_RET = 16'h00ee;
  localparam int STACK_N = 16;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        changed;
    logic [7:0]  rdata;
    logic [1:0]  status;
    logic [11:0] pc;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [11:0] cfg_wr_data = '0;

  chip8_instruction_executor_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial forever #4 clk = ~clk;

  // predictor state
  logic [7:0]  mem [MEM_BYTES];
  bit          wr_ok [MEM_BYTES];
  logic [7:0]  vreg [16];
  logic [11:0] ireg, pc;
  logic [11:0] stk [STACK_N];
  int          sp;
  logic [7:0]  fb [FB_BYTES];
  logic        halted;

  logic [31:0] cmd_q [$];
  result_t     result_q [$];
  int errors = 0, n_exec = 0, n_draw = 0, n_fault = 0, n_halt = 0, n_cfg = 0;
  bit calm = 0;

  function automatic logic [1:0] run_opcode(input logic [15:0] op, input logic [7:0] rnd,
                                            output logic fc);
    logic [3:0] x, y, n;
    logic [7:0] nn, vx, vy, bits;
    logic [11:0] nnn;
    logic [8:0] sum;
    int row, col, idx;
    logic hit;
    x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
    vx = vreg[x]; vy = vreg[y]; fc = 1'b0;
    case (op[15:12])
      OP_SYS: begin
        if (op == OP_CLS) begin
          for (int b = 0; b < FB_BYTES; b++) fb[b] = 8'h00;
          fc = 1'b1;
        end else if (op == OP_RET) begin
          if (sp == 0) return STS_STACK;
          sp--;
          pc = stk[sp];
        end
      end
      OP_JP: pc = nnn;
      OP_CALL: begin
        if (sp >= STACK_N) return STS_STACK;
        stk[sp] = pc; sp++; pc = nnn;
      end
      OP_SEQ: if (vx == nn) pc = pc + 12'd2;
      OP_SNE: if (vx != nn) pc = pc + 12'd2;
      OP_SEQR: if (n == 4'h0 && vx == vy) pc = pc + 12'd2;
      OP_LDV: vreg[x] = nn;
      OP_ADDV: vreg[x] = vx + nn;
      OP_ALU: begin
        case (n)
          ALU_MOV: vreg[x] = vy;
          ALU_OR:  vreg[x] = vx | vy;
          ALU_AND: vreg[x] = vx & vy;
          ALU_XOR: vreg[x] = vx ^ vy;
          ALU_ADD: begin sum = vx + vy; vreg[x] = sum[7:0]; vreg[15] = {7'd0, sum[8]}; end
          ALU_SUB: begin vreg[x] = vx - vy; vreg[15] = {7'd0, vx >= vy}; end
          ALU_SHR: begin vreg[x] = vy >> 1; vreg[15] = {7'd0, vy[0]}; end
          ALU_RSUB: begin vreg[x] = vy - vx; vreg[15] = {7'd0, vy >= vx}; end
          ALU_SHL: begin vreg[x] = vy << 1; vreg[15] = {7'd0, vy[7]}; end
          default: ;
        endcase
      end
      OP_SNER: if (n == 4'h0 && vx != vy) pc = pc + 12'd2;
      OP_LDI: ireg = nnn;
      OP_JPV: pc = {4'h0, vreg[0]} + nnn;
      OP_RND: vreg[x] = rnd & nn;
      OP_DRW: begin
        hit = 1'b0;
        for (int r = 0; r < n; r++) begin
          row = vy[4:0] + r;
          if (row >= 32) break;
          bits = mem[12'(ireg + r)];
          for (int c = 0; c < 8; c++) begin
            col = vx[5:0] + c;
            if (col >= 64) break;
            if (bits[7-c]) begin
              idx = row * 64 + col;
              if (fb[idx >> 3][7 - (idx & 7)]) hit = 1'b1;
              fb[idx >> 3][7 - (idx & 7)] ^= 1'b1;
            end
          end
        end
        vreg[15] = {7'd0, hit};
        fc = 1'b1;
      end
      OP_MISC: begin
        if (nn == MISC_BCD) begin
          mem[ireg] = 8'(vx / 100);
          mem[12'(ireg + 1)] = 8'((vx / 10) % 10);
          mem[12'(ireg + 2)] = 8'(vx % 10);
          wr_ok[ireg] = 1'b1;
          wr_ok[12'(ireg + 1)] = 1'b1;
          wr_ok[12'(ireg + 2)] = 1'b1;
        end else if (nn == MISC_STORE) begin
          for (int k = 0; k <= x; k++) begin
            mem[12'(ireg + k)] = vreg[k];
            wr_ok[12'(ireg + k)] = 1'b1;
          end
        end else if (nn == MISC_LOAD) begin
          for (int k = 0; k <= x; k++) vreg[k] = mem[12'(ireg + k)];
        end
      end
      default: ;
    endcase
    return STS_OK;
  endfunction

  function automatic result_t core_step(input logic [1:0] cmd, input logic [11:0] addr,
                                       input logic [7:0] wd, input logic [7:0] rnd);
    result_t res;
    logic [15:0] op;
    logic fc;
    res = '0;
    case (cmd)
      CMD_WRITE: begin mem[addr] = wd; wr_ok[addr] = 1'b1; end
      CMD_READ:  res.rdata = mem[addr];
      CMD_FRAME: res.rdata = fb[addr[7:0]];
      default: begin
        if (!halted) begin
          if (pc == PC_LAST) begin
            halted = 1'b1; n_halt++;
          end else begin
            op = {mem[pc], mem[pc + 12'd1]};
            pc = pc + 12'd2;
            res.status = run_opcode(op, rnd, fc);
            res.changed = fc;
            n_exec++;
            if (op[15:12] == OP_DRW) n_draw++;
            if (res.status == STS_STACK) n_fault++;
          end
        end
      end
    endcase
    if (halted) res.status = STS_HALT;
    res.pc = pc;
    return res;
  endfunction

  task automatic push_item(input logic [1:0] cmd, input logic [11:0] addr,
                           input logic [7:0] wd, input logic [7:0] rnd);
    result_q.push_back(core_step(cmd, addr, wd, rnd));
    cmd_q.push_back({2'b00, rnd, wd, addr, cmd});
  endtask

  // give random contents to any byte of a span that has never been written
  task automatic prime(input logic [11:0] base, input int count);
    logic [11:0] a;
    for (int k = 0; k < count; k++) begin
      a = base + 12'(k);
      if (!wr_ok[a]) push_item(CMD_WRITE, a, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic send(input logic [1:0] cmd, input logic [11:0] addr,
                      input logic [7:0] wd, input logic [7:0] rnd);
    logic [15:0] op;
    if (cmd == CMD_READ) prime(addr, 1);
    if (cmd == CMD_EXEC && !halted && pc != PC_LAST) begin
      prime(pc, 2);
      op = {mem[pc], mem[pc + 12'd1]};
      if (op[15:12] == OP_DRW) prime(ireg, int'(op[3:0]));
      if (op[15:12] == OP_MISC && op[7:0] == MISC_LOAD) prime(ireg, int'(op[11:8]) + 1);
    end
    push_item(cmd, addr, wd, rnd);
  endtask

  // place an opcode at the PC, then execute it
  task automatic exec_op(input logic [15:0] op);
    send(CMD_WRITE, pc, op[15:8], 8'($urandom));
    send(CMD_WRITE, pc + 12'd1, op[7:0], 8'($urandom));
    send(CMD_EXEC, 12'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic set_start(input logic [11:0] addr);
    while (cmd_q.size() != 0 || result_q.size() != 0 || in_tvalid) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pc = addr; halted = 1'b0; n_cfg++;
  endtask

  function automatic logic [15:0] random_op();
    logic [15:0] op;
    logic [3:0] alu_codes [9] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
                                   ALU_SUB, ALU_SHR, ALU_RSUB, ALU_SHL};
    op = 16'($urandom);
    case ($urandom_range(0, 19))
      0: op = OP_CLS;
      1, 2: op = OP_RET;
      3: op = {OP_CALL, 12'($urandom)};
      4, 5: op = {OP_DRW, op[11:0]};
      6: op = {OP_MISC, op[11:8], MISC_BCD};
      7: op = {OP_MISC, op[11:8], MISC_STORE};
      8: op = {OP_MISC, op[11:8], MISC_LOAD};
      9, 10, 11: op = {OP_ALU, op[11:4], alu_codes[$urandom_range(0, 8)]};
      default: ;
    endcase
    return op;
  endfunction

  // input driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        in_tdata <= cmd_q.pop_front();
        in_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 15);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor, stall generator and watchdog
  int out_gap = 0;
  int idle_cycles = 0;
  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 15);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[22:0];
        if (result_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got.pc !== want.pc) begin
            $display("%0t: pc expected %h actual %h", $time, want.pc, got.pc); errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.rdata !== want.rdata) begin
            $display("%0t: read data expected %h actual %h", $time, want.rdata, got.rdata);
            errors++;
          end
          if (got.changed !== want.changed) begin
            $display("%0t: frame changed expected %b actual %b", $time, want.changed,
                     got.changed);
            errors++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("chip8_instruction_executor_top_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [11:0] starts [4] = '{12'h000, 12'habc, 12'hffe, 12'h3c1};
    int kind;
    for (int a = 0; a < MEM_BYTES; a++) begin
      mem[a] = 8'h00;
      wr_ok[a] = 1'b0;
    end
    for (int r = 0; r < 16; r++) vreg[r] = 8'h00;
    for (int b = 0; b < FB_BYTES; b++) fb[b] = 8'h00;
    for (int s = 0; s < STACK_N; s++) stk[s] = '0;
    ireg = '0; pc = START_RESET; sp = 0; halted = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    exec_op(OP_RET);                         // return with empty stack
    exec_op(16'h6fff); exec_op(16'h6101);
    exec_op(16'h8f14);                       // carry, flag wins over VX
    exec_op(16'h6200); exec_op(16'h8215);    // borrow
    exec_op(16'h63ff); exec_op(16'h8f36);    // shift right, flag in VF
    exec_op(16'h843e); exec_op(16'h8347);
    exec_op(16'h83f3); exec_op(16'h5231);    // undefined 5XYn
    exec_op(16'h33ff); exec_op(16'h9120);
    exec_op(16'hc5ff); exec_op(16'hcf00);
    exec_op(16'hafff); exec_op(16'hf333);    // BCD of 255 across the wrap
    exec_op(16'hff55); exec_op(16'hafff); exec_op(16'hff65);
    exec_op(16'h653c); exec_op(16'h661e); exec_op(16'ha000);
    exec_op(16'hd56f); exec_op(16'hd56f);    // clipped sprite, then erase
    send(CMD_FRAME, 12'hfff, 8'h00, 8'h00);
    exec_op(16'h00e0); exec_op(16'hb7f0);
    exec_op(16'h2400); exec_op(OP_RET);
    for (int k = 0; k <= STACK_N; k++) exec_op({OP_CALL, pc});   // overflow
    exec_op(16'h1fff); exec_op(16'h1000);    // jump to the last byte halts
    send(CMD_FRAME, 12'h0ff, 8'h00, 8'h00);
    send(CMD_WRITE, 12'h123, 8'ha5, 8'h00);
    send(CMD_READ, 12'h123, 8'h00, 8'h00);

    set_start(12'hfff);
    send(CMD_EXEC, 12'h000, 8'h00, 8'h00);
    send(CMD_READ, 12'hfff, 8'h00, 8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      set_start(starts[ph]);
      if (ph == 3) calm = 1;
      for (int i = 0; i < 30; i++) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) exec_op(random_op());
        else if (kind == 7) send(CMD_EXEC, 12'($urandom), 8'($urandom), 8'($urandom));
        else if (kind == 8) send(CMD_READ, 12'($urandom), 8'($urandom), 8'($urandom));
        else send(CMD_FRAME, 12'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    while (cmd_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Executed %0d opcodes (%0d draws, %0d stack faults), %0d halts, %0d starts set",
             n_exec, n_draw, n_fault, n_halt, n_cfg);
    if (errors == 0) begin
      $display("chip8_instruction_executor_top_test: done, clean");
    end else begin
      $display("chip8_instruction_executor_top_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/c8x_pkg.sv
sv/c8x_ctrl.sv
sv/c8x_datapath.sv
sv/chip8_instruction_executor_top.sv
sv/c8x_checker.sv
bench/chip8_instruction_executor_top_test.sv
